// ----- rtl/sfq_pkg.sv -----
package sfq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int FIELD_BITS        = 32;

  typedef struct packed {
    logic                  restart;
    logic                  push_first;
    logic [FIELD_BITS-1:0] first_word;
    logic                  push_second;
    logic [FIELD_BITS-1:0] second_word;
    logic                  pop_req;
  } cmd_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] head_word;
    logic                  is_full;
    logic                  is_empty;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_STORE2
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic finish;
    logic store2;
  } ctrl_cmd_t;

  typedef struct packed {
    logic take2;
  } dp_status_t;

endpackage

// ----- rtl/sfq_if.sv -----
interface sfq_cmd_if;
  import sfq_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sfq_rsp_if;
  import sfq_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/sfq_ctrl.sv -----
module sfq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  sfq_pkg::dp_status_t    status,
  output sfq_pkg::ctrl_cmd_t     ctl
);
  import sfq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free) state_next = status.take2 ? ST_STORE2 : ST_IDLE;
      end
      ST_STORE2: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.finish  = 1'b0;
    ctl.store2  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_LOOK: begin
        ctl.finish = out_free;
      end
      ST_STORE2: begin
        ctl.store2 = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    out_valid_next = ctl.finish ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

// ----- rtl/sfq_datapath.sv -----
module sfq_datapath #(
  parameter int DEPTH     = sfq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = sfq_pkg::WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sfq_pkg::cmd_item_t   item_in,
  input  sfq_pkg::ctrl_cmd_t   ctl,
  output sfq_pkg::dp_status_t  status,
  output sfq_pkg::rsp_item_t   rsp_item
);
  import sfq_pkg::*;

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_SLOT  = PTR_BITS'(DEPTH - 1);

  function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data;
  cmd_item_t            item;
  logic [PTR_BITS-1:0]  read_ptr;
  logic [PTR_BITS-1:0]  write_ptr;
  logic [CNT_BITS-1:0]  fill;
  logic [CNT_BITS-1:0]  wcount;

  logic                 empty;
  logic                 full;
  logic                 byp1;
  logic                 byp2;
  logic                 take1;
  logic                 do_pop;
  logic                 slot_written;
  logic [WORD_BITS-1:0] w1;
  logic [WORD_BITS-1:0] w2;
  logic [WORD_BITS-1:0] stored_head;
  logic [WORD_BITS-1:0] head;
  logic [CNT_BITS-1:0]  fill_after1;
  logic [CNT_BITS-1:0]  wcount_inc;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  always_comb begin
    w1           = WORD_BITS'(item.first_word);
    w2           = WORD_BITS'(item.second_word);
    empty        = (fill == '0);
    full         = (fill == FULL_COUNT);
    byp1         = item.push_first && item.pop_req && empty;
    byp2         = !item.push_first && item.push_second && item.pop_req && empty;
    slot_written = CNT_BITS'(read_ptr) < wcount;
    stored_head  = slot_written ? rd_data : WORD_BITS'(read_ptr);
    if (item.restart) head = '0;
    else if (byp1) head = w1;
    else if (byp2) head = w2;
    else if (empty) head = '0;
    else head = stored_head;
    take1        = !item.restart && item.push_first && !byp1 && !full;
    fill_after1  = fill + CNT_BITS'(take1);
    status.take2 = !item.restart && item.push_second && !byp2 && (fill_after1 != FULL_COUNT);
    do_pop       = !item.restart && item.pop_req && !empty;
    wcount_inc   = (wcount == FULL_COUNT) ? wcount : wcount + 1'b1;
    wr_en        = (ctl.finish && take1) || ctl.store2;
    wr_data      = ctl.store2 ? w2 : w1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[write_ptr] <= wr_data;
    if (ctl.capture) rd_data <= mem[read_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) item <= item_in;
    if (ctl.finish) begin
      rsp_item.head_word <= FIELD_BITS'(head);
      rsp_item.is_full   <= full;
      rsp_item.is_empty  <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      write_ptr <= '0;
      fill      <= FULL_COUNT;
      wcount    <= '0;
    end else if (ctl.finish) begin
      if (item.restart) begin
        read_ptr  <= '0;
        write_ptr <= '0;
        fill      <= FULL_COUNT;
        wcount    <= '0;
      end else begin
        if (take1) begin
          write_ptr <= next_slot(write_ptr);
          wcount    <= wcount_inc;
        end
        if (do_pop) read_ptr <= next_slot(read_ptr);
        fill <= fill_after1 - CNT_BITS'(do_pop);
      end
    end else if (ctl.store2) begin
      write_ptr <= next_slot(write_ptr);
      wcount    <= wcount_inc;
      fill      <= fill + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_COUNT)
    else $error("fill count above depth");

  a_wcount_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= FULL_COUNT)
    else $error("written-slot count above depth");

  a_store2_room: assert property (@(posedge clk) disable iff (rst)
    ctl.store2 |-> (fill != FULL_COUNT))
    else $error("second push stored into a full queue");

  a_store2_follows: assert property (@(posedge clk) disable iff (rst)
    ctl.store2 |-> $past(ctl.finish))
    else $error("second push store without a finished item");
`endif

endmodule

// ----- rtl/slot_free_queue_dual_push.sv -----
// a result is registered from the captured item once the output is free
// a new item is taken only in the idle state, after the last one is finished
//   and any second push stored, as the entry memory has a single write port
// reset: synchronous; queue comes up full holding slot numbers 0 to DEPTH-1,
//   untouched entries read as their slot number through a written-slot count
module slot_free_queue_dual_push #(
  parameter int DEPTH     = sfq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = sfq_pkg::WORD_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sfq_cmd_if.sink   cmd,
  sfq_rsp_if.source rsp
);
  import sfq_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t status;
  rsp_item_t  rsp_item;

  sfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .ctl       (ctl)
  );

  sfq_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .item_in  (cmd.payload),
    .ctl      (ctl),
    .status   (status),
    .rsp_item (rsp_item)
  );

  assign rsp.payload = rsp_item;

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfq_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int WORD_BITS  = WORD_BITS_DEFAULT;
  localparam int LAT_CYCLES = 8;
  localparam int ITEMS_EACH = 440;

  logic clk = 1'b0;
  logic rst;

  sfq_cmd_if cmd ();
  sfq_rsp_if rsp ();

  slot_free_queue_dual_push #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // free-slot queue as it should look after each accepted item
  logic [WORD_BITS-1:0] slot_mem [DEPTH];
  int unsigned          slot_rd;
  int unsigned          slot_wr;
  int unsigned          slot_cnt;

  rsp_item_t   head_q[$];
  int          errors = 0;
  int unsigned tx_idle_pct = 17;
  int unsigned rx_idle_pct = 68;

  always #6 clk = ~clk;

  function automatic void reload_slots();
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = WORD_BITS'(i);
    slot_rd  = 0;
    slot_wr  = 0;
    slot_cnt = DEPTH;
  endfunction

  function automatic void store_slot(logic [FIELD_BITS-1:0] w);
    slot_mem[slot_wr] = WORD_BITS'(w);
    slot_wr = (slot_wr + 1) % DEPTH;
    slot_cnt++;
  endfunction

  function automatic rsp_item_t step_slots(cmd_item_t c);
    rsp_item_t r;
    logic      was_empty;
    logic      byp1;
    logic      byp2;
    was_empty = (slot_cnt == 0);
    byp1 = c.push_first && c.pop_req && was_empty;
    byp2 = !c.push_first && c.push_second && c.pop_req && was_empty;
    r.is_full  = (slot_cnt >= DEPTH);
    r.is_empty = was_empty;
    if (byp1) begin
      r.head_word = FIELD_BITS'(WORD_BITS'(c.first_word));
    end else if (byp2) begin
      r.head_word = FIELD_BITS'(WORD_BITS'(c.second_word));
    end else if (was_empty) begin
      r.head_word = '0;
    end else begin
      r.head_word = FIELD_BITS'(slot_mem[slot_rd]);
    end
    if (c.restart) begin
      reload_slots();
      r.head_word = FIELD_BITS'(slot_mem[0]);
    end else begin
      if (c.push_first && !byp1 && slot_cnt < DEPTH) store_slot(c.first_word);
      if (c.push_second && !byp2 && slot_cnt < DEPTH) store_slot(c.second_word);
      if (c.pop_req && !was_empty) begin
        slot_rd = (slot_rd + 1) % DEPTH;
        slot_cnt--;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 50) $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // prediction on accepted items, checking on accepted results
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (head_q.size() == 0) begin
          report_mismatch("result with no item pending");
        end else begin
          want = head_q[0];
          head_q.delete(0);
          if (rsp.payload.head_word !== want.head_word)
            report_mismatch($sformatf("head_word got %h want %h",
                                      rsp.payload.head_word, want.head_word));
          if (rsp.payload.is_full !== want.is_full)
            report_mismatch($sformatf("is_full got %b want %b",
                                      rsp.payload.is_full, want.is_full));
          if (rsp.payload.is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %b want %b",
                                      rsp.payload.is_empty, want.is_empty));
        end
      end
      if (cmd.valid && cmd.ready) head_q = {head_q, step_slots(cmd.payload)};
    end
  end

  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic cmd_item_t mk_cmd(logic rs, logic p1, logic [FIELD_BITS-1:0] w1,
                                       logic p2, logic [FIELD_BITS-1:0] w2, logic pop);
    cmd_item_t c;
    c.restart     = rs;
    c.push_first  = p1;
    c.first_word  = w1;
    c.push_second = p2;
    c.second_word = w2;
    c.pop_req     = pop;
    return c;
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(cmd_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.payload <= it;
    cmd.valid   <= 1'b1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (head_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic run_traffic(int n);
    cmd_item_t   it;
    int unsigned fill_bias;
    fill_bias = 50;
    for (int k = 0; k < n; k++) begin
      // swing between filling and draining so both ends are reached
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(2))
          0: fill_bias = 15;
          1: fill_bias = 85;
          default: fill_bias = 50;
        endcase
      end
      it.restart     = ($urandom_range(59) == 0);
      it.push_first  = ($urandom_range(99) < fill_bias);
      it.first_word  = rand_word();
      it.push_second = ($urandom_range(99) < (fill_bias * 2) / 3);
      it.second_word = rand_word();
      it.pop_req     = ($urandom_range(99) >= fill_bias) || ($urandom_range(3) == 0);
      send_item(it);
    end
    wait_drained();
  endtask

  task automatic test_directed();
    send_item(mk_cmd(1'b0, 1'b0, '0, 1'b0, '0, 1'b0));
    // pushes on a full queue are dropped
    send_item(mk_cmd(1'b0, 1'b1, '1, 1'b1, '1, 1'b0));
    send_item(mk_cmd(1'b0, 1'b1, '1, 1'b0, '0, 1'b1));
    // one free slot: first push takes it, second is dropped
    send_item(mk_cmd(1'b0, 1'b1, '0, 1'b1, '1, 1'b0));
    send_item(mk_cmd(1'b1, 1'b1, 32'h0000_5a5a, 1'b1, 32'h0000_a5a5, 1'b1));
    for (int i = 0; i < DEPTH; i++)
      send_item(mk_cmd(1'b0, 1'b0, FIELD_BITS'($urandom), 1'b0, FIELD_BITS'($urandom), 1'b1));
    // pop on empty, then bypass cases
    send_item(mk_cmd(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
    send_item(mk_cmd(1'b0, 1'b1, '1, 1'b1, 32'h0000_1234, 1'b1));
    send_item(mk_cmd(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
    send_item(mk_cmd(1'b0, 1'b0, '0, 1'b1, '1, 1'b1));
    send_item(mk_cmd(1'b0, 1'b0, '0, 1'b1, 32'h0000_beef, 1'b0));
    send_item(mk_cmd(1'b1, 1'b0, '0, 1'b0, '0, 1'b0));
    wait_drained();
  endtask

  task automatic test_slow_receiver();
    tx_idle_pct = 17;
    rx_idle_pct = 68;
    run_traffic(ITEMS_EACH);
  endtask

  task automatic test_slow_sender();
    tx_idle_pct = 68;
    rx_idle_pct = 17;
    run_traffic(ITEMS_EACH);
  endtask

  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(ITEMS_EACH);
  endtask

  initial begin
    rst         <= 1'b1;
    cmd.valid   <= 1'b0;
    cmd.payload <= '0;
    reload_slots();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfq_pkg.sv
rtl/sfq_if.sv
rtl/sfq_ctrl.sv
rtl/sfq_datapath.sv
rtl/slot_free_queue_dual_push.sv
test/tb.sv
